@@ rtl/core/gbs_pkg.sv @@
`default_nettype none

package gbs_pkg;

	// Default capacity of the kept-box list.
	localparam int MAX_KEPT_DEF = 64;

	// Reset value of the IoU threshold (about 0.45 in Q0.16).
	localparam logic [15:0] IOU_THR_RESET = 16'd29491;

	localparam int COORD_W = 16;
	localparam int OV_W    = COORD_W + 1;
	localparam int AREA_W  = 2 * COORD_W;
	localparam int INTER_W = 2 * OV_W;
	localparam int UNION_W = AREA_W + 1;
	localparam int PROD_W  = COORD_W + UNION_W;
	localparam int SCALED_W = INTER_W + COORD_W;

	localparam int TOTAL_W  = 7;
	localparam int OUT_W    = 16;
	localparam int OUT_USED = TOTAL_W + 2;

	// One box, left edge in the lowest bits.
	typedef struct packed {
		logic [COORD_W-1:0] tall;
		logic [COORD_W-1:0] wide;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] left;
	} box_t;

	// Status of the shared IoU unit toward the sequencer.
	typedef struct packed {
		logic busy;
		logic hit_vld;
		logic hit;
	} iou_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ rtl/core/greedy_box_suppression.sv @@
`default_nettype none

// Greedy non-maximum suppression by intersection over union.
//
// Boxes come in on the s_ stream in descending score order, one request at
// a time. s_tuser marks the first box of a frame, which empties the kept
// list first. Each box is compared with every stored box of the frame by
// one pipelined IoU unit; the test is inter * 65536 > threshold * union,
// with an empty union counting as IoU zero. A surviving box is appended to
// the list, or flagged as overflow when the list already holds MAX_KEPT.
// One result request per box leaves on the m_ stream.
//
// With N stored boxes, the list memory feeds N reads, one a cycle, into the
// five-stage IoU unit. s_tready is low while a box is in work and rises as
// its result appears, so a new box is not taken before the last one is
// through. The result sits in an output register; if the receiver stalls,
// the next box is still accepted and scanned, and the sequencer only waits
// at the end until the output register frees.
// The user must write the threshold over the cfg_ channel only while the block is idle; not enforced.
// Reset empties the list and loads a threshold of 29491 (about 0.45).
module greedy_box_suppression import gbs_pkg::*; #(
	parameter int MAX_KEPT = MAX_KEPT_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	input  wire logic [63:0]  s_tdata,    // box_left, box_top, box_wide, box_tall
	input  wire logic [0:0]   s_tuser,    // new_frame
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	output      logic [15:0]  m_tdata,    // keep, overflow, kept_total[6:0], zero pad
	input  wire logic         cfg_valid,
	output      logic         cfg_ready,
	input  wire logic [15:0]  cfg_data    // iou_threshold
);

	localparam int CNT_W  = $clog2(MAX_KEPT + 1);
	localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

	state_t             state_q, state_d;
	box_t               box_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic               hit_q;
	logic [COORD_W-1:0] thr_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	logic               accept;
	logic               rd_en;
	logic               load_out;
	logic               wr_en;
	logic               full;
	logic               keep;
	logic               in_flight;
	logic [CNT_W-1:0]   count_next;
	logic               rd_vld;
	box_t               rd_data;
	iou_status_t        iou_st;

	assign accept    = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;
	assign full      = (count_q == CNT_W'(MAX_KEPT));
	assign keep      = ~hit_q;
	assign in_flight = rd_vld | iou_st.busy;

	// Sequencer: scan the stored boxes, drain the IoU unit, then post the result.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q < count_q) begin
					rd_en = 1'b1;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!in_flight) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign wr_en      = load_out & keep & ~full;
	assign count_next = count_q + CNT_W'(wr_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			thr_q      <= IOU_THR_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (accept) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				if (s_tuser[0]) begin
					count_q <= '0;
				end
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (iou_st.hit_vld && iou_st.hit) begin
					hit_q <= 1'b1;
				end
				count_q <= count_next;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			box_q <= box_t'(s_tdata);
		end
		if (load_out) begin
			m_tdata_q <= {{(OUT_W-OUT_USED){1'b0}}, TOTAL_W'(count_next), keep & full, keep};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	gbs_box_store #(
		.DEPTH  (MAX_KEPT),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (box_q),
		.rd_en   (rd_en),
		.rd_addr (idx_q[ADDR_W-1:0]),
		.rd_vld  (rd_vld),
		.rd_data (rd_data)
	);

	gbs_iou_unit u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (rd_vld),
		.box_p  (box_q),
		.box_q  (rd_data),
		.thr    (thr_q),
		.status (iou_st)
	);

endmodule

`default_nettype wire

@@ rtl/core/gbs_box_store.sv @@
`default_nettype none

module gbs_box_store import gbs_pkg::*; #(
	parameter int DEPTH  = MAX_KEPT_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire box_t              wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic              rd_vld,
	output      box_t              rd_data
);

	box_t mem_q [DEPTH];
	logic rd_vld_q;
	box_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= rd_en;
		end
	end

	assign rd_vld  = rd_vld_q;
	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/core/gbs_iou_unit.sv @@
`default_nettype none

module gbs_iou_unit import gbs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_vld,
	input  wire box_t               box_p,
	input  wire box_t               box_q,
	input  wire logic [COORD_W-1:0] thr,
	output      iou_status_t        status
);

	// Overlap of two intervals along one axis; ends use one extra bit.
	function automatic logic [OV_W-1:0] overlap(input logic [COORD_W-1:0] a0,
		input logic [COORD_W-1:0] alen, input logic [COORD_W-1:0] b0,
		input logic [COORD_W-1:0] blen);
		logic [OV_W-1:0] a1;
		logic [OV_W-1:0] b1;
		logic [OV_W-1:0] lo;
		logic [OV_W-1:0] hi;
		a1 = {1'b0, a0} + {1'b0, alen};
		b1 = {1'b0, b0} + {1'b0, blen};
		lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
		hi = (a1 < b1) ? a1 : b1;
		return (hi > lo) ? (hi - lo) : '0;
	endfunction

	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [OV_W-1:0]     ovx_s1, ovy_s1;
	logic [COORD_W-1:0]  pw_s1, ph_s1, qw_s1, qh_s1;
	logic [INTER_W-1:0]  inter_s2, inter_s3, inter_s4;
	logic [AREA_W-1:0]   ap_s2, aq_s2;
	logic [UNION_W-1:0]  uni_s3, uni_s4;
	logic [PROD_W-1:0]   prod_s4;
	logic                hit_s5;
	logic [UNION_W:0]    uni_sum;
	logic [SCALED_W-1:0] scaled;

	assign uni_sum = {2'b00, ap_s2} + {2'b00, aq_s2} - inter_s2;
	assign scaled  = {inter_s4, {COORD_W{1'b0}}};

	always_ff @(posedge clk) begin
		ovx_s1   <= overlap(box_p.left, box_p.wide, box_q.left, box_q.wide);
		ovy_s1   <= overlap(box_p.top, box_p.tall, box_q.top, box_q.tall);
		pw_s1    <= box_p.wide;
		ph_s1    <= box_p.tall;
		qw_s1    <= box_q.wide;
		qh_s1    <= box_q.tall;
		inter_s2 <= INTER_W'(ovx_s1) * INTER_W'(ovy_s1);
		ap_s2    <= AREA_W'(pw_s1) * AREA_W'(ph_s1);
		aq_s2    <= AREA_W'(qw_s1) * AREA_W'(qh_s1);
		inter_s3 <= inter_s2;
		uni_s3   <= uni_sum[UNION_W-1:0];
		inter_s4 <= inter_s3;
		uni_s4   <= uni_s3;
		prod_s4  <= PROD_W'(thr) * PROD_W'(uni_s3);
		// An empty union counts as IoU zero.
		hit_s5   <= (uni_s4 != '0) && (scaled > {{(SCALED_W-PROD_W){1'b0}}, prod_s4});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign status.busy    = vld_s1 | vld_s2 | vld_s3 | vld_s4 | vld_s5;
	assign status.hit_vld = vld_s5;
	assign status.hit     = hit_s5;

endmodule

`default_nettype wire
